FILE: design/cstp_pkg.sv
// ----------------------------------------------------------------------------
// cstp_pkg
// types and constants for the exclusive time profiler
// ----------------------------------------------------------------------------
package cstp_pkg;

  localparam int unsigned FuncIdW = 7;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned LimitW  = 8;

  localparam logic [TimeW-1:0] TimeSat = '1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FuncIdW-1:0] func_id;
    logic [TimeW-1:0]   timestamp;
  } in_word_t;

  typedef struct packed {
    logic [FuncIdW-1:0] result_func_id;
    logic [TimeW-1:0]   time_value;
    logic [1:0]         status;
  } out_word_t;

  // one open call on the stack
  typedef struct packed {
    logic [FuncIdW-1:0] func;
    logic [TimeW-1:0]   start;
    logic [TimeW-1:0]   child;
  } stk_entry_t;

  function automatic logic [TimeW-1:0] sat_add(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeSat : s[TimeW-1:0];
  endfunction

endpackage

FILE: design/cstp_chan_if.sv
// ----------------------------------------------------------------------------
// cstp_chan_if
// valid/ready channel carrying one word of a given type
// ----------------------------------------------------------------------------
interface cstp_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/cstp_ram.sv
// ----------------------------------------------------------------------------
// cstp_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module cstp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/call_stack_exclusive_time_profiler.sv
// ----------------------------------------------------------------------------
// call_stack_exclusive_time_profiler
// exclusive time per function from entry/exit events on a bounded call stack
// ----------------------------------------------------------------------------
//  channel  dir  payload                               accepted when
//  in_i     in   cmd, func_id, timestamp               in_i.valid & in_i.ready
//  out_o    out  result_func_id, time_value, status    out_o.valid & out_o.ready
//  cfg_i    in   num_functions (8 bit)                 cfg_i.valid (ready tied high)
//
//  each word passes idle, which issues the memory reads, then execute, which
//  modifies and writes back the stack ram and the totals ram (registered reads)
//  after reset all MAX_FUNCS totals are swept to zero, in_i.ready low
//  a result waits in the output register; the next word is accepted meanwhile
//  and holds in the execute cycle until that register frees up
// ----------------------------------------------------------------------------
module call_stack_exclusive_time_profiler
  import cstp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned MAX_FUNCS   = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cstp_chan_if.sink   in_i,
  cstp_chan_if.source out_o,
  cstp_chan_if.sink   cfg_i
);

  localparam int unsigned StkAw  = $clog2(STACK_DEPTH);
  localparam int unsigned LvlW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FuncAw = $clog2(MAX_FUNCS);
  localparam int unsigned EntryW = $bits(stk_entry_t);

  // control state
  state_e             state_q, state_d;
  logic [LvlW-1:0]    level_q;
  logic [FuncAw-1:0]  clr_q;
  logic [LimitW-1:0]  num_q;
  logic               out_valid_q;

  // word held for the execute cycle
  logic [1:0]         cmd_q;
  logic [FuncIdW-1:0] fid_q;
  logic [TimeW-1:0]   span_q;
  out_word_t          out_q;

  // top of stack kept in flops, the rest lives in the stack ram
  stk_entry_t         top_q;

  logic               accept, out_free, done, clr_last;
  logic               in_ready;

  // ram ports
  logic               stk_we, stk_re, tot_we, tot_re;
  logic [StkAw-1:0]   stk_waddr, stk_raddr;
  logic [EntryW-1:0]  stk_rdata;
  stk_entry_t         stk_wdata, below;
  logic [FuncAw-1:0]  tot_waddr, tot_raddr;
  logic [TimeW-1:0]   tot_wdata, tot_rdata;

  // datapath
  logic [TimeW-1:0]   diff, span_d, excl;
  logic [LvlW-1:0]    lvl_m1, lvl_m2;
  logic               range_err, full, empty;
  out_word_t          res;

  assign accept   = in_i.valid & in_ready;
  assign out_free = ~out_valid_q | out_o.ready;
  assign done     = (state_q == S_EXEC) & out_free;
  assign clr_last = (clr_q == FuncAw'(MAX_FUNCS - 1));

  assign lvl_m1 = level_q - LvlW'(1);
  assign lvl_m2 = level_q - LvlW'(2);
  assign below  = stk_entry_t'(stk_rdata);

  // checks use the limit capped at the table size
  assign range_err = (32'(fid_q) >= 32'(num_q)) || (32'(fid_q) >= MAX_FUNCS);
  assign full      = (level_q == LvlW'(STACK_DEPTH));
  assign empty     = (level_q == '0);

  // span of the top call, end - start + 1, zero if time ran backwards
  assign diff = in_i.data.timestamp - top_q.start;
  always_comb begin
    if (in_i.data.timestamp < top_q.start) begin
      span_d = '0;
    end else if (diff == TimeSat) begin
      span_d = TimeSat;
    end else begin
      span_d = diff + TimeW'(1);
    end
  end

  assign excl = (span_q > top_q.child) ? (span_q - top_q.child) : '0;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------------------
  // memory and handshake controls
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    stk_re    = 1'b0;
    tot_re    = 1'b0;
    stk_we    = 1'b0;
    tot_we    = 1'b0;
    tot_waddr = FuncAw'(top_q.func);
    tot_wdata = sat_add(tot_rdata, excl);
    case (state_q)
      S_CLEAR: begin
        tot_we    = 1'b1;
        tot_waddr = clr_q;
        tot_wdata = '0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        stk_re   = in_i.valid;
        tot_re   = in_i.valid;
      end
      S_EXEC: begin
        if (out_free) begin
          case (cmd_q)
            CMD_START: stk_we = ~range_err & ~full & ~empty;
            CMD_END:   tot_we = ~empty;
            default:   ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // end reads the entry below the top and the popped id's total
  assign stk_raddr = lvl_m2[StkAw-1:0];
  assign tot_raddr = (in_i.data.cmd == CMD_END) ? FuncAw'(top_q.func)
                                                : FuncAw'(in_i.data.func_id);
  // push spills the current top into the ram
  assign stk_waddr = lvl_m1[StkAw-1:0];
  assign stk_wdata = top_q;

  // ---------------------------------------------------------------------------
  // result of the execute cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    res.result_func_id = fid_q;
    res.time_value     = '0;
    res.status         = STAT_OK;
    case (cmd_q)
      CMD_START: begin
        if (range_err) begin
          res.status = STAT_RANGE;
        end else if (full) begin
          res.status = STAT_FULL;
        end
      end
      CMD_END: begin
        if (empty) begin
          res.status         = STAT_EMPTY;
          res.result_func_id = '0;
        end else begin
          res.result_func_id = top_q.func;
          res.time_value     = excl;
        end
      end
      CMD_READ: begin
        if (range_err) begin
          res.status = STAT_RANGE;
        end else begin
          res.time_value = tot_rdata;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      level_q     <= '0;
      clr_q       <= '0;
      num_q       <= LimitW'(128);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + FuncAw'(1);
      if (cfg_i.valid) num_q <= cfg_i.data;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (done) begin
        case (cmd_q)
          CMD_START: if (!range_err && !full) level_q <= level_q + LvlW'(1);
          CMD_END:   if (!empty) level_q <= lvl_m1;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_i.data.cmd;
      fid_q  <= in_i.data.func_id;
      // start parks its timestamp in span_q's slot
      span_q <= (in_i.data.cmd == CMD_START) ? in_i.data.timestamp : span_d;
    end
    if (done) begin
      out_q <= res;
      case (cmd_q)
        CMD_START: begin
          if (!range_err && !full) begin
            top_q.func  <= fid_q;
            top_q.start <= span_q;
            top_q.child <= '0;
          end
        end
        CMD_END: begin
          // new top comes from the ram, crediting the closed call's span
          if (level_q > LvlW'(1)) begin
            top_q.func  <= below.func;
            top_q.start <= below.start;
            top_q.child <= sat_add(below.child, span_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  cstp_ram #(
    .Width (EntryW),
    .Depth (STACK_DEPTH)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  cstp_ram #(
    .Width (TimeW),
    .Depth (MAX_FUNCS)
  ) u_tot_ram (
    .clk_i   (clk_i),
    .we_i    (tot_we),
    .waddr_i (tot_waddr),
    .wdata_i (tot_wdata),
    .re_i    (tot_re),
    .raddr_i (tot_raddr),
    .rdata_o (tot_rdata)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LvlW'(STACK_DEPTH))
    else $error("stack level above depth");

  a_level_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q != $past(level_q)) |-> ($past(state_q) == S_EXEC))
    else $error("stack level moved outside execute");

  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EXEC))
    else $error("result appeared without execute cycle");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == S_EXEC))
    else $error("accepted word did not enter execute");

endmodule
